@@ design/refcounted_block_pool_allocator_macros.svh @@
// Assertion helpers for the block pool allocator.
`ifndef REFCOUNTED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, reset-qualified.
`define RCBPA_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, reset-qualified.
`define RCBPA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RCBPA_ASSERT_NOW(label, ck, rn, ante, cons, msg)
`define RCBPA_ASSERT_NEXT(label, ck, rn, ante, cons, msg)
`endif

`endif

@@ design/rcbpa_pkg.sv @@
package rcbpa_pkg;

    localparam int NUM_BLOCKS_DEFAULT  = 256;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_RETAIN  = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_INVALID   = 2'd2;
    localparam logic [1:0] STATUS_SATURATED = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] owner_id;
        logic [7:0]  block_index;
    } request_t;

    typedef struct packed {
        logic [7:0]  result_index;
        logic [1:0]  status;
        logic        became_free;
        logic [8:0]  free_count;
        logic [63:0] access_stamp;
    } response_t;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_RETAIN  = 2'd2,
        KIND_REJECT  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] block_index;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ design/refcounted_block_pool_allocator.sv @@
// Reference-counted block pool: a transaction is accepted when start is high and busy is low,
// and its result appears for one cycle with done high; there is no way to hold a result off.
// The execution unit first reads the count and free-stack memories at issue, then updates
// them and forms the result, and it finishes one transaction before it issues the next; a
// two-entry command queue in front lets start be taken while execution is under way. When
// the queue is empty at acceptance, the command is written to the queue, issued from it to
// the execution unit, and its result is registered with done. After reset, busy stays high
// while the count memory is swept to zero. Owner ids and per-block stamps are not stored,
// since no transaction reads them back; the returned stamp is the global tick.
`include "refcounted_block_pool_allocator_macros.svh"

module refcounted_block_pool_allocator #(
    parameter int NUM_BLOCKS  = rcbpa_pkg::NUM_BLOCKS_DEFAULT,
    parameter int COUNT_WIDTH = rcbpa_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rcbpa_pkg::request_t  request,
    output logic                 busy,
    output logic                 done,
    output rcbpa_pkg::response_t response
);

    rcbpa_pkg::queue_status_t q_stat;
    rcbpa_pkg::cmd_t          push_cmd;
    rcbpa_pkg::cmd_t          head;
    logic                     push;
    logic                     pop;
    logic                     clearing;

    rcbpa_front #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_front (
        .start    (start),
        .request  (request),
        .q_stat   (q_stat),
        .clearing (clearing),
        .busy     (busy),
        .push     (push),
        .cmd      (push_cmd)
    );

    rcbpa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    rcbpa_back #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .done     (done),
        .response (response)
    );

    `RCBPA_ASSERT_NEXT(a_result_spacing, clk, rst_n, done, !done,
        "results closer than two cycles")
    `RCBPA_ASSERT_NOW(a_empty_means_zero, clk, rst_n,
        done && response.status == rcbpa_pkg::STATUS_EMPTY,
        response.free_count == '0, "empty status with free blocks left")
    `RCBPA_ASSERT_NOW(a_freed_is_ok, clk, rst_n, done && response.became_free,
        response.status == rcbpa_pkg::STATUS_OK && response.access_stamp == '0,
        "freed block with bad status or stamp")
    `RCBPA_ASSERT_NOW(a_stamp_only_on_use, clk, rst_n, done && response.access_stamp != '0,
        response.status == rcbpa_pkg::STATUS_OK ||
        response.status == rcbpa_pkg::STATUS_SATURATED, "stamp on a failed transaction")

endmodule

@@ design/rcbpa_front.sv @@
module rcbpa_front #(
    parameter int NUM_BLOCKS = rcbpa_pkg::NUM_BLOCKS_DEFAULT
) (
    input  logic                     start,
    input  rcbpa_pkg::request_t      request,
    input  rcbpa_pkg::queue_status_t q_stat,
    input  logic                     clearing,
    output logic                     busy,
    output logic                     push,
    output rcbpa_pkg::cmd_t          cmd
);

    localparam logic [31:0] NUM_LIMIT = 32'(NUM_BLOCKS);

    logic in_range;

    assign busy     = q_stat.full || clearing;
    assign push     = start && !busy;
    assign in_range = 32'(request.block_index) < NUM_LIMIT;

    // Classify: out-of-range release/retain and unused codes go straight to reject
    always_comb
    begin
        cmd.block_index = request.block_index;
        unique case (request.operation)
            rcbpa_pkg::OP_ALLOC:
                cmd.kind = rcbpa_pkg::KIND_ALLOC;
            rcbpa_pkg::OP_RELEASE:
                cmd.kind = in_range ? rcbpa_pkg::KIND_RELEASE : rcbpa_pkg::KIND_REJECT;
            rcbpa_pkg::OP_RETAIN:
                cmd.kind = in_range ? rcbpa_pkg::KIND_RETAIN : rcbpa_pkg::KIND_REJECT;
            default:
                cmd.kind = rcbpa_pkg::KIND_REJECT;
        endcase
    end

endmodule

@@ design/rcbpa_queue.sv @@
module rcbpa_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  rcbpa_pkg::cmd_t          push_cmd,
    input  logic                     pop,
    output rcbpa_pkg::cmd_t          head,
    output rcbpa_pkg::queue_status_t q_stat
);

    localparam logic [rcbpa_pkg::QPTR_W-1:0] PTR_LAST =
        rcbpa_pkg::QPTR_W'(rcbpa_pkg::QUEUE_DEPTH - 1);
    localparam logic [rcbpa_pkg::QCNT_W-1:0] CNT_FULL =
        rcbpa_pkg::QCNT_W'(rcbpa_pkg::QUEUE_DEPTH);

    rcbpa_pkg::cmd_t                slot_reg [rcbpa_pkg::QUEUE_DEPTH];
    logic [rcbpa_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rcbpa_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rcbpa_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign head         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ design/rcbpa_back.sv @@
module rcbpa_back #(
    parameter int NUM_BLOCKS  = rcbpa_pkg::NUM_BLOCKS_DEFAULT,
    parameter int COUNT_WIDTH = rcbpa_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  rcbpa_pkg::queue_status_t q_stat,
    input  rcbpa_pkg::cmd_t          head,
    output logic                     pop,
    output logic                     clearing,
    output logic                     done,
    output rcbpa_pkg::response_t     response
);

    localparam int IDX_W   = $clog2(NUM_BLOCKS);
    localparam int DEPTH_W = $clog2(NUM_BLOCKS + 1);
    localparam logic [DEPTH_W-1:0]     DEPTH_FULL = DEPTH_W'(NUM_BLOCKS);
    localparam logic [IDX_W-1:0]       IDX_LAST   = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        clr_idx_reg, clr_idx_next;
    logic [DEPTH_W-1:0]      depth_reg, depth_next;
    logic [DEPTH_W-1:0]      low_mark_reg, low_mark_next;
    logic [63:0]             tick_reg, tick_next;
    logic                    done_reg, done_next;
    rcbpa_pkg::response_t    response_reg, response_next;

    // Transaction in flight, latched at issue
    rcbpa_pkg::kind_t        kind_reg;
    logic [7:0]              bi_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic                    init_sel_reg;

    logic [COUNT_WIDTH-1:0]  cnt_mem [NUM_BLOCKS];
    logic [IDX_W-1:0]        stack_mem [NUM_BLOCKS];
    logic [COUNT_WIDTH-1:0]  cnt_rd_reg;
    logic [IDX_W-1:0]        slot_rd_reg;

    logic                    issue;
    logic [31:0]             head_bi_ext;
    logic [IDX_W-1:0]        head_idx;
    logic [DEPTH_W-1:0]      depth_m1;
    logic                    cnt_we;
    logic [IDX_W-1:0]        cnt_waddr;
    logic [COUNT_WIDTH-1:0]  cnt_wdata;
    logic                    stk_we;
    logic [IDX_W-1:0]        pidx;
    logic [31:0]             pidx_ext;
    logic [31:0]             depth_ext;
    logic [63:0]             tick_inc;
    logic                    live;

    assign issue       = (state_reg == ST_IDLE) && !q_stat.empty;
    assign pop         = issue;
    assign clearing    = (state_reg == ST_CLEAR);
    assign done        = done_reg;
    assign response    = response_reg;

    assign head_bi_ext = 32'(head.block_index);
    assign head_idx    = head_bi_ext[IDX_W-1:0];
    assign depth_m1    = depth_reg - DEPTH_W'(1);
    assign tick_inc    = tick_reg + 64'd1;
    assign live        = (cnt_rd_reg != '0);
    // Stack slots below the low-water mark were never overwritten: they hold their own index
    assign pidx        = init_sel_reg ? pos_reg : slot_rd_reg;
    assign pidx_ext    = 32'(pidx);
    assign depth_ext   = 32'(depth_next);

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        depth_next    = depth_reg;
        low_mark_next = low_mark_reg;
        tick_next     = tick_reg;
        done_next     = 1'b0;
        cnt_we        = 1'b0;
        cnt_waddr     = idx_reg;
        cnt_wdata     = '0;
        stk_we        = 1'b0;

        response_next.result_index = bi_reg;
        response_next.status       = rcbpa_pkg::STATUS_INVALID;
        response_next.became_free  = 1'b0;
        response_next.access_stamp = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (issue)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                unique case (kind_reg)
                    rcbpa_pkg::KIND_ALLOC:
                    begin
                        if (depth_reg == '0)
                        begin
                            response_next.status       = rcbpa_pkg::STATUS_EMPTY;
                            response_next.result_index = '0;
                        end
                        else
                        begin
                            cnt_we        = 1'b1;
                            cnt_waddr     = pidx;
                            cnt_wdata     = COUNT_ONE;
                            depth_next    = depth_m1;
                            low_mark_next = (depth_m1 < low_mark_reg) ? depth_m1 : low_mark_reg;
                            tick_next     = tick_inc;
                            response_next.status       = rcbpa_pkg::STATUS_OK;
                            response_next.result_index = pidx_ext[7:0];
                            response_next.access_stamp = tick_inc;
                        end
                    end
                    rcbpa_pkg::KIND_RELEASE:
                    begin
                        if (live)
                        begin
                            cnt_we    = 1'b1;
                            cnt_wdata = cnt_rd_reg - COUNT_ONE;
                            response_next.status = rcbpa_pkg::STATUS_OK;
                            if (cnt_rd_reg == COUNT_ONE)
                            begin
                                response_next.became_free = 1'b1;
                                // Drop the push if the stack is somehow full
                                if (depth_reg < DEPTH_FULL)
                                begin
                                    stk_we     = 1'b1;
                                    depth_next = depth_reg + DEPTH_W'(1);
                                end
                            end
                        end
                    end
                    rcbpa_pkg::KIND_RETAIN:
                    begin
                        if (live)
                        begin
                            tick_next = tick_inc;
                            response_next.access_stamp = tick_inc;
                            if (cnt_rd_reg == COUNT_MAX)
                            begin
                                response_next.status = rcbpa_pkg::STATUS_SATURATED;
                            end
                            else
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_rd_reg + COUNT_ONE;
                                response_next.status = rcbpa_pkg::STATUS_OK;
                            end
                        end
                    end
                    rcbpa_pkg::KIND_REJECT:
                    begin
                        response_next.status = rcbpa_pkg::STATUS_INVALID;
                    end
                    default:
                    begin
                        response_next.status = rcbpa_pkg::STATUS_INVALID;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        response_next.free_count = depth_ext[8:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_idx_reg  <= '0;
            depth_reg    <= DEPTH_FULL;
            low_mark_reg <= DEPTH_FULL;
            tick_reg     <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            depth_reg    <= depth_next;
            low_mark_reg <= low_mark_next;
            tick_reg     <= tick_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            kind_reg     <= head.kind;
            bi_reg       <= head.block_index;
            idx_reg      <= head_idx;
            pos_reg      <= depth_m1[IDX_W-1:0];
            init_sel_reg <= (depth_m1 < low_mark_reg);
        end
        if (state_reg == ST_EXEC)
        begin
            response_reg <= response_next;
        end
    end

    // Reference counts: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (issue)
        begin
            cnt_rd_reg <= cnt_mem[head_idx];
        end
    end

    // Free stack: push at the depth, read the top at issue
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[depth_reg[IDX_W-1:0]] <= idx_reg;
        end
        if (issue)
        begin
            slot_rd_reg <= stack_mem[depth_m1[IDX_W-1:0]];
        end
    end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                     NB          = rcbpa_pkg::NUM_BLOCKS_DEFAULT;
    localparam int                     CW          = rcbpa_pkg::COUNT_WIDTH_DEFAULT;
    localparam logic [CW-1:0]          COUNT_TOP   = '1;
    localparam logic [1:0]             OP_RESERVED = 2'd3;
    localparam logic [63:0]            ALL_ONES    = '1;

    // Stimulus mix for one random phase.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } mix_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    rcbpa_pkg::request_t  request = '0;
    logic                 busy;
    logic                 done;
    rcbpa_pkg::response_t response;

    // Mirror of the pool state, updated at each accepted transaction.
    logic [7:0]    pool_stack [NB];
    logic [8:0]    pool_depth;
    logic [CW-1:0] pool_cnt [NB];
    logic [63:0]   pool_tick;

    rcbpa_pkg::response_t pool_results_due [$];
    rcbpa_pkg::response_t due_resp;

    int unsigned   err_count   = 0;
    int unsigned   n_accepted  = 0;
    int unsigned   n_alloc     = 0;
    int unsigned   n_empty     = 0;
    int unsigned   n_freed     = 0;
    int unsigned   n_invalid   = 0;
    int unsigned   n_saturated = 0;
    int unsigned   n_retain_ok = 0;
    int unsigned   n_checked   = 0;

    bit            start_parked = 1'b1;
    bit            idle_en      = 1'b1;
    int unsigned   burst_left   = 0;

    refcounted_block_pool_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .busy     (busy),
        .done     (done),
        .response (response)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one transaction to the mirrored pool and return its response.
    function automatic rcbpa_pkg::response_t predict_pool_op(rcbpa_pkg::request_t req);
        rcbpa_pkg::response_t r;
        logic [7:0] blk;
        logic [7:0] idx;
        bit         live;
        r = '0;
        blk = req.block_index;
        live = (pool_cnt[blk] != '0);
        r.result_index = blk;
        r.status = rcbpa_pkg::STATUS_INVALID;
        case (req.operation)
            rcbpa_pkg::OP_ALLOC:
            begin
                r.result_index = '0;
                if (pool_depth == '0)
                begin
                    r.status = rcbpa_pkg::STATUS_EMPTY;
                end
                else
                begin
                    pool_depth = pool_depth - 1'b1;
                    idx = pool_stack[pool_depth[7:0]];
                    pool_cnt[idx] = CW'(1);
                    pool_tick = pool_tick + 1'b1;
                    r.result_index = idx;
                    r.status = rcbpa_pkg::STATUS_OK;
                    r.access_stamp = pool_tick;
                end
            end
            rcbpa_pkg::OP_RELEASE:
            begin
                if (live)
                begin
                    pool_cnt[blk] = pool_cnt[blk] - 1'b1;
                    r.status = rcbpa_pkg::STATUS_OK;
                    if (pool_cnt[blk] == '0)
                    begin
                        r.became_free = 1'b1;
                        // drop the push if the stack is somehow full
                        if (pool_depth < NB)
                        begin
                            pool_stack[pool_depth[7:0]] = blk;
                            pool_depth = pool_depth + 1'b1;
                        end
                    end
                end
            end
            rcbpa_pkg::OP_RETAIN:
            begin
                if (live)
                begin
                    if (pool_cnt[blk] == COUNT_TOP)
                        r.status = rcbpa_pkg::STATUS_SATURATED;
                    else
                    begin
                        pool_cnt[blk] = pool_cnt[blk] + 1'b1;
                        r.status = rcbpa_pkg::STATUS_OK;
                    end
                    pool_tick = pool_tick + 1'b1;
                    r.access_stamp = pool_tick;
                end
            end
            default:
            begin
                r.status = rcbpa_pkg::STATUS_INVALID;
            end
        endcase
        r.free_count = pool_depth;
        return r;
    endfunction

    // Random live block if there is one, else any index.
    function automatic logic [7:0] pick_live_block();
        int unsigned s;
        logic [7:0]  idx;
        s = $urandom_range(0, NB - 1);
        for (int k = 0; k < NB; k++)
        begin
            idx = 8'((s + k) % NB);
            if (pool_cnt[idx] != '0)
                return idx;
        end
        return 8'(s);
    endfunction

    function automatic logic [63:0] rand_owner();
        return {$urandom, $urandom};
    endfunction

    task automatic send_req(input logic [1:0] op, input logic [63:0] owner,
                            input logic [7:0] blk);
        rcbpa_pkg::request_t  req;
        rcbpa_pkg::response_t exp;
        int unsigned gap;
        req.operation   = op;
        req.owner_id    = owner;
        req.block_index = blk;
        start   <= 1'b1;
        request <= req;
        start_parked = 1'b0;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        exp = predict_pool_op(req);
        pool_results_due = {pool_results_due, exp};
        n_accepted++;
        if (op == rcbpa_pkg::OP_ALLOC && exp.status == rcbpa_pkg::STATUS_OK)
            n_alloc++;
        if (exp.status == rcbpa_pkg::STATUS_EMPTY)
            n_empty++;
        if (exp.status == rcbpa_pkg::STATUS_INVALID)
            n_invalid++;
        if (exp.status == rcbpa_pkg::STATUS_SATURATED)
            n_saturated++;
        if (op == rcbpa_pkg::OP_RETAIN && exp.status == rcbpa_pkg::STATUS_OK)
            n_retain_ok++;
        if (exp.became_free)
            n_freed++;
        if (idle_en)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 8);
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(0, 8);
                start <= 1'b0;
                start_parked = 1'b1;
                repeat (gap)
                    @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Hold the sender until every outstanding response has come back.
    task automatic wait_quiet();
        if (!start_parked)
        begin
            start <= 1'b0;
            start_parked = 1'b1;
        end
        while (pool_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(input string name, input logic [63:0] exp,
                                 input logic [63:0] act);
        if (exp !== act)
        begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp, act);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pool_results_due.size() == 0)
            begin
                $display("%0t: response with none outstanding: expected none actual %h",
                         $time, response);
                err_count++;
            end
            else
            begin
                due_resp = pool_results_due.pop_front();
                n_checked++;
                compare_field("result_index", 64'(due_resp.result_index),
                              64'(response.result_index));
                compare_field("status", 64'(due_resp.status), 64'(response.status));
                compare_field("became_free", 64'(due_resp.became_free),
                              64'(response.became_free));
                compare_field("free_count", 64'(due_resp.free_count),
                              64'(response.free_count));
                compare_field("access_stamp", due_resp.access_stamp,
                              response.access_stamp);
            end
        end
    end

    // Corner cases: extreme fields, every operation, invalid targets, LIFO reuse.
    task automatic test_directed();
        send_req(rcbpa_pkg::OP_ALLOC,   64'd0,        8'd0);
        send_req(rcbpa_pkg::OP_ALLOC,   ALL_ONES,     8'd255);
        send_req(rcbpa_pkg::OP_RETAIN,  rand_owner(), 8'd254);
        send_req(rcbpa_pkg::OP_RETAIN,  64'd0,        8'd255);
        send_req(rcbpa_pkg::OP_RELEASE, 64'd0,        8'd254);
        send_req(rcbpa_pkg::OP_RELEASE, ALL_ONES,     8'd254);
        send_req(rcbpa_pkg::OP_RELEASE, 64'd0,        8'd254);
        send_req(rcbpa_pkg::OP_RETAIN,  64'd0,        8'd254);
        send_req(rcbpa_pkg::OP_RELEASE, 64'd0,        8'd0);
        send_req(rcbpa_pkg::OP_RETAIN,  ALL_ONES,     8'd0);
        send_req(OP_RESERVED,           rand_owner(), 8'd255);
        send_req(OP_RESERVED,           64'd0,        8'd0);
        send_req(rcbpa_pkg::OP_ALLOC,   64'h5555_5555_5555_5555, 8'd255);
        send_req(rcbpa_pkg::OP_RELEASE, 64'd0,        8'd255);
        send_req(rcbpa_pkg::OP_RELEASE, 64'd0,        8'd255);
        send_req(rcbpa_pkg::OP_RELEASE, 64'd0,        8'd255);
        send_req(rcbpa_pkg::OP_RETAIN,  64'd0,        8'haa);
        send_req(rcbpa_pkg::OP_RELEASE, 64'd0,        8'd254);
        send_req(rcbpa_pkg::OP_ALLOC,   64'haaaa_aaaa_aaaa_aaaa, 8'h55);
        send_req(rcbpa_pkg::OP_RELEASE, 64'd0,        8'd254);
    endtask

    // Run the pool dry, allocate past empty, then return every block.
    task automatic test_exhaust();
        while (pool_depth != '0)
            send_req(rcbpa_pkg::OP_ALLOC, rand_owner(), 8'($urandom_range(0, NB - 1)));
        send_req(rcbpa_pkg::OP_ALLOC, rand_owner(), 8'd0);
        send_req(rcbpa_pkg::OP_ALLOC, ALL_ONES, 8'd255);
        send_req(rcbpa_pkg::OP_RETAIN, rand_owner(), pick_live_block());
        while (pool_depth != NB)
            send_req(rcbpa_pkg::OP_RELEASE, rand_owner(), pick_live_block());
        send_req(rcbpa_pkg::OP_ALLOC, rand_owner(), 8'd0);
    endtask

    task automatic test_random(input int unsigned n_items);
        mix_t        mix;
        int unsigned phase_left;
        int unsigned roll;
        int unsigned alloc_lim;
        int unsigned release_lim;
        logic [7:0]  blk;
        phase_left = 0;
        alloc_lim = 35;
        release_lim = 70;
        for (int unsigned i = 0; i < n_items; i++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(50, 300);
                mix = mix_t'($urandom_range(0, 2));
                case (mix)
                    MIX_FILL:
                    begin
                        alloc_lim = 65;
                        release_lim = 80;
                    end
                    MIX_DRAIN:
                    begin
                        alloc_lim = 15;
                        release_lim = 75;
                    end
                    default:
                    begin
                        alloc_lim = 35;
                        release_lim = 70;
                    end
                endcase
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            blk = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, NB - 1))
                                              : pick_live_block();
            if (roll < alloc_lim)
                send_req(rcbpa_pkg::OP_ALLOC, rand_owner(), 8'($urandom_range(0, NB - 1)));
            else if (roll < release_lim)
                send_req(rcbpa_pkg::OP_RELEASE, rand_owner(), blk);
            else if (roll < 97)
                send_req(rcbpa_pkg::OP_RETAIN, rand_owner(), blk);
            else
                send_req(OP_RESERVED, rand_owner(), 8'($urandom_range(0, NB - 1)));
        end
    endtask

    // Stack many references on one block, then drop them one by one.
    task automatic test_shared();
        logic [7:0]  blk;
        int unsigned n_refs;
        while (pool_depth == '0)
            send_req(rcbpa_pkg::OP_RELEASE, rand_owner(), pick_live_block());
        blk = pool_stack[pool_depth[7:0] - 1'b1];
        n_refs = $urandom_range(16, 24);
        send_req(rcbpa_pkg::OP_ALLOC, rand_owner(), 8'd0);
        // keep the queue full while the references pile up
        idle_en = 1'b0;
        repeat (n_refs)
            send_req(rcbpa_pkg::OP_RETAIN, rand_owner(), blk);
        idle_en = 1'b1;
        while (pool_cnt[blk] != '0)
            send_req(rcbpa_pkg::OP_RELEASE, rand_owner(), blk);
        send_req(rcbpa_pkg::OP_RETAIN, rand_owner(), blk);
        send_req(rcbpa_pkg::OP_RELEASE, rand_owner(), blk);
    endtask

    initial
    begin
        for (int i = 0; i < NB; i++)
        begin
            pool_stack[i] = 8'(i);
            pool_cnt[i] = '0;
        end
        pool_depth = 9'(NB);
        pool_tick = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        wait_quiet();
        test_exhaust();
        wait_quiet();
        test_random(1270);
        wait_quiet();
        test_shared();
        wait_quiet();

        repeat (10)
            @(posedge clk);
        $display("Ran %0d transactions, %0d responses checked: %0d allocations, %0d frees,",
                 n_accepted, n_checked, n_alloc, n_freed);
        $display("%0d good retains, %0d empty-pool, %0d invalid-target, %0d saturated.",
                 n_retain_ok, n_empty, n_invalid, n_saturated);
        if (err_count == 0 && pool_results_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d responses outstanding", pool_results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
